### design/fsd_pkg.sv
// Shared types, constants and configuration decode for the spectral derivative block.
`timescale 1ns / 1ps
package fsd_pkg;

   // Largest column length and the field widths of the datapath.
   localparam int MAX_LEN    = 4096;
   localparam int LEN_W      = 13;
   localparam int IDX_W      = 12;
   localparam int DATA_W     = 32;
   localparam int SCALE_W    = 32;
   localparam int NORM_W     = 31;
   localparam int ORDER_W    = 3;
   localparam int TREAT_W    = 2;
   localparam int W_W        = LEN_W + SCALE_W;
   localparam int NORM_SHIFT = 30;
   localparam int STEP_SHIFT = 24;
   localparam int MAX_ORDER  = 4;

   // Register port geometry.
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 3;

   // Register indexes.
   localparam logic [REG_IDX_W-1:0] REG_ORDER   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_TREAT   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FULL    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_DEALIAS = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SCALE   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_NORM    = 3'd5;

   // Rules for the k-equal-zero columns; code zero applies the normal rule.
   localparam logic [TREAT_W-1:0] TREAT_PASS   = 2'd1;
   localparam logic [TREAT_W-1:0] TREAT_NEGATE = 2'd2;
   localparam logic [TREAT_W-1:0] TREAT_MEAN   = 2'd3;

   // Register reset values.
   localparam logic [ORDER_W-1:0] ORDER_RST   = 3'd1;
   localparam logic [TREAT_W-1:0] TREAT_RST   = 2'd0;
   localparam logic [LEN_W-1:0]   FULL_RST    = 13'd4096;
   localparam logic [LEN_W-1:0]   DEALIAS_RST = 13'd4096;
   localparam logic [SCALE_W-1:0] SCALE_RST   = 32'h0100_0000;
   localparam logic [NORM_W-1:0]  NORM_RST    = 31'h4000_0000;

   localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_LEN);
   localparam logic [LEN_W-1:0]   LEN_MIN   = 13'd2;
   localparam logic [ORDER_W-1:0] ORDER_MAX = ORDER_W'(MAX_ORDER);

   // Input transaction.
   typedef struct packed {
      logic signed [DATA_W-1:0] coef_re;
      logic signed [DATA_W-1:0] coef_im;
      logic [IDX_W-1:0]         mode_index;
      logic                     zero_k_column;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic signed [DATA_W-1:0] out_re;
      logic signed [DATA_W-1:0] out_im;
   } rsp_type;

   // Complex value inside the pipeline.
   typedef struct packed {
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
   } cpx_type;

   // Per-item control that travels alongside the data.
   typedef struct packed {
      logic           neg;
      logic           deriv;
      logic           kneg;
      logic [W_W-1:0] w;
   } ctl_type;

   // Operation select for one multiply-round unit.
   typedef struct packed {
      logic mag_neg;
      logic neg_a;
      logic neg_b;
      logic swap;
      logic bypass;
   } op_type;

   // Decoded configuration, held in registers by the register block.
   typedef struct packed {
      logic [ORDER_W-1:0] order;
      logic [TREAT_W-1:0] treat;
      logic [LEN_W-1:0]   m_lim;
      logic [LEN_W-1:0]   pos_m;
      logic [LEN_W-1:0]   pos_d;
      logic [LEN_W-1:0]   neg_start;
      logic [LEN_W-1:0]   neg_half;
      logic [SCALE_W-1:0] scale;
      logic [NORM_W-1:0]  norm;
   } cfg_type;

   // Clamp the lengths and the order and work out the band edges.
   function automatic cfg_type fsd_derive(
      input logic [ORDER_W-1:0] order,
      input logic [TREAT_W-1:0] treat,
      input logic [LEN_W-1:0]   full,
      input logic [LEN_W-1:0]   dealias,
      input logic [SCALE_W-1:0] scale,
      input logic [NORM_W-1:0]  norm
   );
      cfg_type          c;
      logic [LEN_W-1:0] len;
      logic [LEN_W-1:0] dlen;
      if (full > LEN_MAX) begin
         len = LEN_MAX;
      end else if (full < LEN_MIN) begin
         len = LEN_MIN;
      end else begin
         len = full;
      end
      dlen        = (dealias > len) ? len : dealias;
      c.order     = (order > ORDER_MAX) ? ORDER_MAX : order;
      c.treat     = treat;
      c.m_lim     = len;
      c.neg_half  = len >> 1;
      c.pos_m     = len - (len >> 1);
      c.pos_d     = dlen - (dlen >> 1);
      c.neg_start = len - (dlen >> 1);
      c.scale     = scale;
      c.norm      = norm;
      return c;
   endfunction

endpackage

### design/fsd_csr.sv
// Configuration registers with an APB-style port and the decoded configuration.
`timescale 1ns / 1ps
module fsd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [fsd_pkg::CSR_AW-1:0]   paddr,
   input  logic [fsd_pkg::CSR_DW-1:0]   pwdata,
   output logic [fsd_pkg::CSR_DW-1:0]   prdata,
   output logic                         pready,
   output fsd_pkg::cfg_type             cfg
);
   import fsd_pkg::*;

   logic [ORDER_W-1:0]   deriv_order_ff, deriv_order_in;
   logic [TREAT_W-1:0]   treatment_ff, treatment_in;
   logic [LEN_W-1:0]     full_length_ff, full_length_in;
   logic [LEN_W-1:0]     dealias_length_ff, dealias_length_in;
   logic [SCALE_W-1:0]   wave_scale_ff, wave_scale_in;
   logic [NORM_W-1:0]    norm_factor_ff, norm_factor_in;
   cfg_type              cfg_ff, cfg_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[CSR_AW-1:2];

   // Register write decode.
   always_comb begin
      deriv_order_in    = deriv_order_ff;
      treatment_in      = treatment_ff;
      full_length_in    = full_length_ff;
      dealias_length_in = dealias_length_ff;
      wave_scale_in     = wave_scale_ff;
      norm_factor_in    = norm_factor_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ORDER:   deriv_order_in    = pwdata[ORDER_W-1:0];
            REG_TREAT:   treatment_in      = pwdata[TREAT_W-1:0];
            REG_FULL:    full_length_in    = pwdata[LEN_W-1:0];
            REG_DEALIAS: dealias_length_in = pwdata[LEN_W-1:0];
            REG_SCALE:   wave_scale_in     = pwdata[SCALE_W-1:0];
            REG_NORM:    norm_factor_in    = pwdata[NORM_W-1:0];
            default: begin
            end
         endcase
      end
      // The decoded copy follows the new values in the same cycle.
      cfg_in = fsd_derive(deriv_order_in, treatment_in, full_length_in,
                          dealias_length_in, wave_scale_in, norm_factor_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deriv_order_ff    <= ORDER_RST;
         treatment_ff      <= TREAT_RST;
         full_length_ff    <= FULL_RST;
         dealias_length_ff <= DEALIAS_RST;
         wave_scale_ff     <= SCALE_RST;
         norm_factor_ff    <= NORM_RST;
         cfg_ff            <= fsd_derive(ORDER_RST, TREAT_RST, FULL_RST,
                                         DEALIAS_RST, SCALE_RST, NORM_RST);
      end else begin
         deriv_order_ff    <= deriv_order_in;
         treatment_ff      <= treatment_in;
         full_length_ff    <= full_length_in;
         dealias_length_ff <= dealias_length_in;
         wave_scale_ff     <= wave_scale_in;
         norm_factor_ff    <= norm_factor_in;
         cfg_ff            <= cfg_in;
      end
   end

   // Read back the raw register values.
   always_comb begin
      case (reg_sel)
         REG_ORDER:   prdata = CSR_DW'(deriv_order_ff);
         REG_TREAT:   prdata = CSR_DW'(treatment_ff);
         REG_FULL:    prdata = CSR_DW'(full_length_ff);
         REG_DEALIAS: prdata = CSR_DW'(dealias_length_ff);
         REG_SCALE:   prdata = CSR_DW'(wave_scale_ff);
         REG_NORM:    prdata = CSR_DW'(norm_factor_ff);
         default:     prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### design/fsd_index.sv
// Wavenumber decode, dealias masking and wavenumber scaling, two pipeline stages.
`timescale 1ns / 1ps
module fsd_index (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fsd_pkg::req_type  in_data,
   input  fsd_pkg::cfg_type  cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output fsd_pkg::cpx_type  out_data,
   output fsd_pkg::ctl_type  out_ctl
);
   import fsd_pkg::*;

   logic             a_en, b_en;
   logic             a_valid_ff, b_valid_ff;
   cpx_type          a_data_ff, a_data_in;
   logic             a_neg_ff, a_neg_in;
   logic             a_deriv_ff, a_deriv_in;
   logic             a_kneg_ff, a_kneg_in;
   logic [LEN_W-1:0] a_kmag_ff, a_kmag_in;
   cpx_type          b_data_ff;
   ctl_type          b_ctl_ff, b_ctl_in;
   logic [LEN_W-1:0] m;
   logic             keep;
   logic             at_edge;

   assign b_en     = ~b_valid_ff | out_ready;
   assign a_en     = ~a_valid_ff | b_en;
   assign in_ready = a_en;

   // Classify the position and pick the wavenumber magnitude and sign.
   always_comb begin
      m          = LEN_W'(in_data.mode_index);
      at_edge    = (m == '0) || (m == cfg.pos_m);
      keep       = 1'b0;
      a_neg_in   = 1'b0;
      a_deriv_in = 1'b0;
      a_kneg_in  = 1'b0;
      a_kmag_in  = '0;
      if (m >= cfg.m_lim) begin
         keep = 1'b0;
      end else if (in_data.zero_k_column && at_edge &&
                   (cfg.treat inside {TREAT_PASS, TREAT_NEGATE})) begin
         keep     = 1'b1;
         a_neg_in = (cfg.treat == TREAT_NEGATE);
      end else if (in_data.zero_k_column && (cfg.treat == TREAT_MEAN)) begin
         if (m == '0) begin
            keep       = 1'b1;
            a_deriv_in = 1'b1;
         end else if (m == cfg.pos_m) begin
            keep       = 1'b1;
            a_deriv_in = 1'b1;
            a_kmag_in  = cfg.neg_half;
            a_kneg_in  = 1'b1;
         end
      end else if (m < cfg.pos_m) begin
         if (m < cfg.pos_d) begin
            keep       = 1'b1;
            a_deriv_in = 1'b1;
            a_kmag_in  = m;
         end
      end else if (m >= cfg.neg_start) begin
         keep       = 1'b1;
         a_deriv_in = 1'b1;
         a_kmag_in  = cfg.m_lim - m;
         a_kneg_in  = 1'b1;
      end
      // A dropped coefficient becomes zero and stays zero downstream.
      if (keep) begin
         a_data_in = cpx_type'{re: in_data.coef_re, im: in_data.coef_im};
      end else begin
         a_data_in = '0;
      end
   end

   // Scaled wavenumber w = k * scale, exact in Q.24.
   always_comb begin
      b_ctl_in.neg   = a_neg_ff;
      b_ctl_in.deriv = a_deriv_ff;
      b_ctl_in.kneg  = a_kneg_ff;
      b_ctl_in.w     = W_W'(a_kmag_ff) * W_W'(cfg.scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_valid_ff <= in_valid;
         end
         if (b_en) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_data_ff  <= a_data_in;
         a_neg_ff   <= a_neg_in;
         a_deriv_ff <= a_deriv_in;
         a_kneg_ff  <= a_kneg_in;
         a_kmag_ff  <= a_kmag_in;
      end
      if (b_en) begin
         b_data_ff <= a_data_ff;
         b_ctl_ff  <= b_ctl_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;
   assign out_ctl   = b_ctl_ff;

endmodule

### design/fsd_mulrnd.sv
// Two-stage complex multiply by a real magnitude with rounding, saturation and negation.
`timescale 1ns / 1ps
module fsd_mulrnd #(
   parameter int SHIFT = 24,
   parameter int MAG_W = 45
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  fsd_pkg::cpx_type  in_data,
   input  fsd_pkg::ctl_type  in_ctl,
   input  fsd_pkg::op_type   op,
   input  logic [MAG_W-1:0]  mag,
   output logic              out_valid,
   input  logic              out_ready,
   output fsd_pkg::cpx_type  out_data,
   output fsd_pkg::ctl_type  out_ctl
);
   import fsd_pkg::*;

   localparam int LO_W  = DATA_W + SHIFT;
   localparam int HI_W  = MAG_W - SHIFT;
   localparam int HP_W  = DATA_W + HI_W;
   localparam int RND_W = HP_W + 1;
   localparam logic [LO_W-1:0]   HALF    = LO_W'(1) << (SHIFT - 1);
   localparam logic [DATA_W-1:0] LIM_POS = {1'b0, {(DATA_W - 1){1'b1}}};
   localparam logic [DATA_W-1:0] LIM_NEG = {1'b1, {(DATA_W - 1){1'b0}}};

   logic                     a_en, b_en;
   logic                     a_valid_ff, b_valid_ff;
   logic signed [DATA_W-1:0] x_in [2];
   logic                     neg_sel [2];
   logic [DATA_W-1:0]        ux [2];
   logic                     xsign [2];
   logic [LO_W-1:0]          a_lo_ff [2], a_lo_in [2];
   logic [HP_W-1:0]          a_hi_ff [2], a_hi_in [2];
   logic                     a_sign_ff [2], a_sign_in [2];
   logic                     a_big_ff [2], a_big_in [2];
   logic                     a_bypass_ff;
   cpx_type                  a_raw_ff;
   ctl_type                  a_ctl_ff;
   logic [RND_W-1:0]         rnd [2];
   logic [DATA_W-1:0]        lim [2];
   logic [DATA_W-1:0]        magc [2];
   logic signed [DATA_W-1:0] res [2];
   cpx_type                  b_data_ff, b_data_in;
   ctl_type                  b_ctl_ff;

   assign b_en     = ~b_valid_ff | out_ready;
   assign a_en     = ~a_valid_ff | b_en;
   assign in_ready = a_en;

   // Stage A: magnitudes and the two partial products of each part.
   always_comb begin
      x_in[0]    = op.swap ? in_data.im : in_data.re;
      x_in[1]    = op.swap ? in_data.re : in_data.im;
      neg_sel[0] = op.neg_a;
      neg_sel[1] = op.neg_b;
      for (int i = 0; i < 2; i++) begin
         xsign[i] = x_in[i][DATA_W-1];
         ux[i]    = xsign[i] ? DATA_W'(-x_in[i]) : DATA_W'(x_in[i]);
         // A product that rounds negative may reach -2^31 unless it is negated after.
         a_sign_in[i] = xsign[i] ^ op.mag_neg ^ neg_sel[i];
         a_big_in[i]  = (xsign[i] ^ op.mag_neg) & ~neg_sel[i];
         a_lo_in[i]   = LO_W'(ux[i]) * LO_W'(mag[SHIFT-1:0]);
         a_hi_in[i]   = HP_W'(ux[i]) * HP_W'(mag[MAG_W-1:SHIFT]);
      end
   end

   // Stage B: round half away from zero, clamp, and apply the sign.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         rnd[i]  = RND_W'(a_hi_ff[i]) + RND_W'((a_lo_ff[i] + HALF) >> SHIFT);
         lim[i]  = a_big_ff[i] ? LIM_NEG : LIM_POS;
         magc[i] = (rnd[i] > RND_W'(lim[i])) ? lim[i] : rnd[i][DATA_W-1:0];
         res[i]  = a_sign_ff[i] ? -magc[i] : magc[i];
      end
      if (a_bypass_ff) begin
         b_data_in = a_raw_ff;
      end else begin
         b_data_in = cpx_type'{re: res[0], im: res[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_valid_ff <= in_valid;
         end
         if (b_en) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_lo_ff     <= a_lo_in;
         a_hi_ff     <= a_hi_in;
         a_sign_ff   <= a_sign_in;
         a_big_ff    <= a_big_in;
         a_bypass_ff <= op.bypass;
         a_raw_ff    <= in_data;
         a_ctl_ff    <= in_ctl;
      end
      if (b_en) begin
         b_data_ff <= b_data_in;
         b_ctl_ff  <= a_ctl_ff;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;
   assign out_ctl   = b_ctl_ff;

endmodule

### design/fourier_spectral_derivative.sv
// Top level of the dealiased spectral derivative of Fourier coefficients.
`timescale 1ns / 1ps
// The block accepts one coefficient per clock when the result side does
// not stall, and returns one result per coefficient, in order. The
// pipeline is the position decode (one stage), the
// wavenumber scaling multiply (one stage), the normalization multiply (two
// stages), four rotation steps by i*k*scale (two stages each, the 32 by 45
// bit product split into two partial products) and the output register.
// Steps beyond the configured order pass the value through but still take
// their two stages, so the latency does not depend on the order. Bubbles
// close up when the result side stalls, so a new coefficient is taken as
// long as any stage is empty. The user must write the registers through the
// APB-style port only while no transaction is in flight; the block does not
// enforce this. A write takes effect for the next accepted coefficient.
module fourier_spectral_derivative (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fsd_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fsd_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fsd_pkg::CSR_AW-1:0]  paddr,
   input  logic [fsd_pkg::CSR_DW-1:0]  pwdata,
   output logic [fsd_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import fsd_pkg::*;

   cfg_type cfg;
   logic    idx_ready;
   logic    idx_valid;
   logic    norm_ready;
   cpx_type idx_data;
   ctl_type idx_ctl;
   op_type  norm_op;
   logic    st_valid [MAX_ORDER + 1];
   logic    st_ready [MAX_ORDER + 1];
   cpx_type st_data [MAX_ORDER + 1];
   ctl_type st_ctl [MAX_ORDER + 1];
   op_type  step_op [MAX_ORDER];
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   fsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fsd_index u_index (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (idx_ready),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (idx_valid),
      .out_ready (norm_ready),
      .out_data  (idx_data),
      .out_ctl   (idx_ctl)
   );

   assign req_stall = ~idx_ready;

   // Normalization, negated for the negate rule.
   always_comb begin
      norm_op.mag_neg = 1'b0;
      norm_op.neg_a   = idx_ctl.neg;
      norm_op.neg_b   = idx_ctl.neg;
      norm_op.swap    = 1'b0;
      norm_op.bypass  = 1'b0;
   end

   fsd_mulrnd #(
      .SHIFT (NORM_SHIFT),
      .MAG_W (NORM_W)
   ) u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (idx_valid),
      .in_ready  (norm_ready),
      .in_data   (idx_data),
      .in_ctl    (idx_ctl),
      .op        (norm_op),
      .mag       (cfg.norm),
      .out_valid (st_valid[0]),
      .out_ready (st_ready[0]),
      .out_data  (st_data[0]),
      .out_ctl   (st_ctl[0])
   );

   // Each step maps (re, im) to (-(im*w), re*w) with w signed by k.
   for (genvar s = 0; s < MAX_ORDER; s++) begin : g_step
      always_comb begin
         step_op[s].mag_neg = st_ctl[s].kneg;
         step_op[s].neg_a   = 1'b1;
         step_op[s].neg_b   = 1'b0;
         step_op[s].swap    = 1'b1;
         step_op[s].bypass  = ~(st_ctl[s].deriv && (cfg.order > ORDER_W'(s)));
      end

      fsd_mulrnd #(
         .SHIFT (STEP_SHIFT),
         .MAG_W (W_W)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (st_valid[s]),
         .in_ready  (st_ready[s]),
         .in_data   (st_data[s]),
         .in_ctl    (st_ctl[s]),
         .op        (step_op[s]),
         .mag       (st_ctl[s].w),
         .out_valid (st_valid[s+1]),
         .out_ready (st_ready[s+1]),
         .out_data  (st_data[s+1]),
         .out_ctl   (st_ctl[s+1])
      );
   end

   // Output register parts the pipeline from the result side.
   assign st_ready[MAX_ORDER] = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      rsp_data_in.out_re = st_data[MAX_ORDER].re;
      rsp_data_in.out_im = st_data[MAX_ORDER].im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (st_ready[MAX_ORDER]) begin
         rsp_valid_ff <= st_valid[MAX_ORDER];
      end
   end

   always_ff @(posedge clock) begin
      if (st_ready[MAX_ORDER] && st_valid[MAX_ORDER]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The input side only waits while the output holds a stalled transaction.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall))
      else $error("input stalled while the output register was free");

   // A taken result with nothing behind it leaves the output empty.
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !st_valid[MAX_ORDER]) |=> !rsp_valid_ff)
      else $error("result repeated after it was taken");

   // The decoded band edges stay consistent with the clamped length.
   a_band: assert property (@(posedge clock) disable iff (reset)
      (cfg.pos_m + cfg.neg_half == cfg.m_lim) && (cfg.pos_d <= cfg.pos_m) &&
      (cfg.neg_start >= cfg.pos_m) && (cfg.m_lim >= LEN_MIN) &&
      (cfg.m_lim <= LEN_MAX))
      else $error("inconsistent decoded column configuration");

endmodule
